>>> rtl/core/tis_pkg.sv
// Package for the telnet IAC stripper: command byte codes and the
// item type passed between the input register and the parser.
// Depends on nothing.
`timescale 1ns / 1ps

package tis_pkg;

  // Telnet command bytes
  localparam logic [7:0] CodeIac  = 8'd255;
  localparam logic [7:0] CodeDont = 8'd254;
  localparam logic [7:0] CodeDo   = 8'd253;
  localparam logic [7:0] CodeWont = 8'd252;
  localparam logic [7:0] CodeWill = 8'd251;
  localparam logic [7:0] CodeSb   = 8'd250;
  localparam logic [7:0] CodeSe   = 8'd240;

  // One received byte held in the input register
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } item_t;

endpackage

>>> rtl/core/tis_in_reg.sv
// Input register of the telnet IAC stripper: captures one received item.
// Depends on tis_pkg.
`timescale 1ns / 1ps

module tis_in_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           rx_valid_i,
  output logic           rx_stall_o,
  input  logic [7:0]     rx_byte_i,
  input  logic           advance_i,
  output tis_pkg::item_t item_o
);

  logic       valid_q;
  logic [7:0] data_q;
  logic       load;

  // Room when empty or when the parser consumes the held item this cycle
  assign load       = !valid_q || advance_i;
  assign rx_stall_o = !load;

  // Valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= rx_valid_i;
    end
  end

  // Payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (load && rx_valid_i) begin
      data_q <= rx_byte_i;
    end
  end

  assign item_o.valid = valid_q;
  assign item_o.data  = data_q;

endmodule

>>> rtl/core/tis_parser.sv
// Telnet parse state machine and result register.
// Depends on tis_pkg.
`timescale 1ns / 1ps

module tis_parser (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tis_pkg::item_t item_i,
  output logic           advance_o,
  output logic           data_valid_o,
  input  logic           data_stall_i,
  output logic [7:0]     data_byte_o
);

  typedef enum logic [2:0] {
    StData   = 3'd0,
    StCmd    = 3'd1,
    StOption = 3'd2,
    StSub    = 3'd3,
    StSubIac = 3'd4
  } state_e;

  state_e     state_q, state_d;
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       emit;
  logic [7:0] emit_byte;

  // Result register free when empty or being taken
  assign advance_o = !out_valid_q || !data_stall_i;

  // Next state and emit decision for the held byte
  always_comb begin
    state_d   = state_q;
    emit      = 1'b0;
    emit_byte = item_i.data;
    case (state_q)
      StCmd: begin
        if (item_i.data == tis_pkg::CodeIac) begin
          emit    = 1'b1;
          state_d = StData;
        end else if (item_i.data inside {tis_pkg::CodeDo, tis_pkg::CodeDont,
                                         tis_pkg::CodeWill, tis_pkg::CodeWont}) begin
          state_d = StOption;
        end else if (item_i.data == tis_pkg::CodeSb) begin
          state_d = StSub;
        end else begin
          state_d = StData;
        end
      end
      StOption: begin
        state_d = StData;
      end
      StSub: begin
        if (item_i.data == tis_pkg::CodeIac) begin
          state_d = StSubIac;
        end
      end
      StSubIac: begin
        state_d = (item_i.data == tis_pkg::CodeSe) ? StData : StSub;
      end
      default: begin
        // normal data, and any unused code acts the same
        if (item_i.data == tis_pkg::CodeIac) begin
          state_d = StCmd;
        end else begin
          emit    = 1'b1;
          state_d = StData;
        end
      end
    endcase
  end

  // State and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StData;
      out_valid_q <= 1'b0;
    end else if (advance_o) begin
      out_valid_q <= item_i.valid && emit;
      if (item_i.valid) begin
        state_q <= state_d;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (advance_o && item_i.valid && emit) begin
      out_byte_q <= emit_byte;
    end
  end

  assign data_valid_o = out_valid_q;
  assign data_byte_o  = out_byte_q;

endmodule

>>> rtl/core/telnet_iac_stripper.sv
// Telnet IAC stripper: forwards user data bytes, swallows telnet commands.
// Path: an accepted byte passes the input register, then the result register, to the output.
// Throughput: one byte per cycle while the output is not stalled; the parse state machine decides combinationally.
// Reset: asynchronous, active low; parse state returns to normal data, both
// the input register and the result register are emptied.
`timescale 1ns / 1ps

module telnet_iac_stripper (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       rx_valid_i,
  output logic       rx_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       data_valid_o,
  input  logic       data_stall_i,
  output logic [7:0] data_byte_o
);

  tis_pkg::item_t item;
  logic           advance;

  // Input register
  tis_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_valid_i),
    .rx_stall_o (rx_stall_o),
    .rx_byte_i  (rx_byte_i),
    .advance_i  (advance),
    .item_o     (item)
  );

  // Parser and result register
  tis_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .advance_o    (advance),
    .data_valid_o (data_valid_o),
    .data_stall_i (data_stall_i),
    .data_byte_o  (data_byte_o)
  );

endmodule

>>> rtl/core/tis_checker.sv
// Port-level checks for the telnet IAC stripper, bound to the top level.
// Depends on telnet_iac_stripper.
`timescale 1ns / 1ps

module tis_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       rx_valid_i,
  input logic       rx_stall_o,
  input logic [7:0] rx_byte_i,
  input logic       data_valid_o,
  input logic       data_stall_i,
  input logic [7:0] data_byte_o
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    data_valid_o && data_stall_i |=> data_valid_o && $stable(data_byte_o))
    else $error("stalled data item changed");

  // A stalled input item holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_valid_i && rx_stall_o |=> rx_valid_i && $stable(rx_byte_i))
    else $error("stalled rx item changed");

  // Input only backs up when the output is blocked
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_stall_o |-> data_valid_o && data_stall_i)
    else $error("input stalled while output free");

  // A new result comes from a byte accepted into the input register and passed on to the result register
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(data_valid_o) |-> $past(rx_valid_i && !rx_stall_o, 2))
    else $error("data item without a source byte");

  // After reset the output is empty
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !data_valid_o)
    else $error("output valid after reset");

endmodule

bind telnet_iac_stripper tis_checker u_tis_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .rx_valid_i   (rx_valid_i),
  .rx_stall_o   (rx_stall_o),
  .rx_byte_i    (rx_byte_i),
  .data_valid_o (data_valid_o),
  .data_stall_i (data_stall_i),
  .data_byte_o  (data_byte_o)
);
